// ===== hw/rtl/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg: shared types and constants for the one-shot timer bank
// Field widths, command and result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ost_pkg;

  localparam int DUR_W       = 16;
  localparam int HDL_W       = 8;
  localparam int SLOT_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int MEM_W       = DUR_W + HDL_W;
  localparam int MAX_NOTICES = 8;
  localparam int NCNT_W      = 4;

  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 16;

  // input selector (tuser)
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kind (tuser)
  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    SRC_REPLY  = 1'b0,
    SRC_NOTICE = 1'b1
  } out_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_TICK_RD,
    S_TICK_UPD,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     idx_clr;
    logic     idx_inc;
    logic     mem_rd;
    logic     add_commit;
    logic     dec_write;
    logic     expire_clr;
    logic     pend_load;
    logic     pend_clr;
    logic     ncnt_clr;
    logic     out_load;
    out_src_t out_src;
    status_t  out_status;
    logic     out_last;
  } ost_cmd_t;

  typedef struct packed {
    logic add_invalid;
    logic slot_active;
    logic idx_last;
    logic expire;
    logic pend_valid;
    logic ncnt_full;
    logic out_free;
  } ost_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/one_shot_timer_slots.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_slots: bank of one-shot countdown timers
// Add requests claim the lowest free slot; tick requests count all active
// slots down and report the slots that run out, up to eight, in slot order.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_tready is high only while the
// sequencer is idle. An add request scans the slot flags one per cycle
// from slot 0 and answers at the first free slot, or with full after
// the last slot; a rejected add answers before any scan. A tick walks
// every slot: a free slot is passed over, an active one takes a registered
// read of the slot memory, then the update; a flush follows the last slot.
// The read and the write-back share the single memory port. Stalls on
// out_tready can hold the add answer, the tick walk and the flush. A tick
// with no expiring slot returns nothing; otherwise up to eight notices,
// the last with tlast. No clearing pass is needed after reset: per-slot
// active flags are cleared at once and the slot memory is only read for
// active slots.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_slots #(
  parameter int SLOT_COUNT = 8   // 1 to 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  // request channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] duration, [23:16] handle
  input  wire logic [ost_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] command: 0 add, 1 tick
  input  wire logic                          in_tuser,

  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [1:0] status, [4:2] slot, [12:5] fired_handle, [15:13] zero
  output logic [ost_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] kind: 0 add reply, 1 expiry notice
  output logic                               out_tuser,
  output logic                               out_tlast
);

  ost_pkg::ost_cmd_t  cmd;
  ost_pkg::ost_stat_t stat;

  // sequencer: add scan, tick walk, notice flush
  ost_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot store, held notice and output register
  ost_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A held notice must have been flushed before a new request is taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.pend_valid)
    else $error("notice still held while idle");

  // Taking a request leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken but sequencer stayed idle");

  // An add reply is always a single result with no handle.
  a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ost_pkg::KIND_REPLY)
      |-> (out_tlast && out_tdata[12:5] == 8'd0))
    else $error("bad add reply fields");

  // A notice carries the nonzero handle stored at add time and ok status.
  a_notice_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ost_pkg::KIND_NOTICE)
      |-> (out_tdata[12:5] != 8'd0 && out_tdata[1:0] == ost_pkg::ST_OK))
    else $error("bad expiry notice fields");

endmodule

`default_nettype wire

// ===== hw/rtl/ost_ctrl.sv =====
// ----------------------------------------------------------------------------
// ost_ctrl: sequencer for the timer bank
// Walks the slots for add and tick requests and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tuser,
  output logic                    in_ready,
  input  wire ost_pkg::ost_stat_t stat,
  output ost_pkg::ost_cmd_t       cmd
);

  ost_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ost_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic go;
    go         = 1'b0;
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.out_src    = ost_pkg::SRC_REPLY;
    cmd.out_status = ost_pkg::ST_OK;

    case (state_r)
      ost_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_tvalid) begin
          cmd.accept   = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.ncnt_clr = 1'b1;
          state_nxt = (in_tuser == ost_pkg::CMD_TICK) ? ost_pkg::S_TICK_RD
                                                       : ost_pkg::S_ADD_SCAN;
        end
      end

      ost_pkg::S_ADD_SCAN: begin
        if (stat.add_invalid) begin
          if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ost_pkg::ST_INVALID;
            state_nxt      = ost_pkg::S_IDLE;
          end
        end else if (!stat.slot_active) begin
          if (stat.out_free) begin
            cmd.add_commit = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_status = ost_pkg::ST_OK;
            state_nxt      = ost_pkg::S_IDLE;
          end
        end else if (stat.idx_last) begin
          if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ost_pkg::ST_FULL;
            state_nxt      = ost_pkg::S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      ost_pkg::S_TICK_RD: begin
        if (stat.slot_active) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ost_pkg::S_TICK_UPD;
        end else if (stat.idx_last) begin
          state_nxt = ost_pkg::S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      ost_pkg::S_TICK_UPD: begin
        if (stat.expire) begin
          if (stat.ncnt_full) begin
            // notice dropped, slot still freed
            cmd.expire_clr = 1'b1;
            go = 1'b1;
          end else if (!stat.pend_valid || stat.out_free) begin
            cmd.out_load   = stat.pend_valid;
            cmd.out_src    = ost_pkg::SRC_NOTICE;
            cmd.out_last   = 1'b0;
            cmd.pend_load  = 1'b1;
            cmd.expire_clr = 1'b1;
            go = 1'b1;
          end
        end else begin
          cmd.dec_write = 1'b1;
          go = 1'b1;
        end
        if (go) begin
          if (stat.idx_last) begin
            state_nxt = ost_pkg::S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ost_pkg::S_TICK_RD;
          end
        end
      end

      ost_pkg::S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ost_pkg::S_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = ost_pkg::SRC_NOTICE;
          cmd.out_last = 1'b1;
          cmd.pend_clr = 1'b1;
          state_nxt    = ost_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ost_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ost_dp.sv =====
// ----------------------------------------------------------------------------
// ost_dp: timer bank datapath
// Slot memory, active flags, slot pointer, held notice and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_dp #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ost_pkg::ost_cmd_t                 cmd,
  output ost_pkg::ost_stat_t                     stat,
  input  wire logic [ost_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ost_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // latched request
  logic [ost_pkg::DUR_W-1:0] dur_r;
  logic [ost_pkg::HDL_W-1:0] hdl_r;

  // slot pointer and active flags (active = slot holds a running timer)
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;

  // slot memory: {handle, remaining ticks}
  logic [ost_pkg::MEM_W-1:0] mem [SLOT_COUNT];
  logic [ost_pkg::MEM_W-1:0] rd_data_r;
  logic [ost_pkg::MEM_W-1:0] wr_data;
  logic                      wr_en;
  logic [ost_pkg::DUR_W-1:0] rd_cnt;
  logic [ost_pkg::HDL_W-1:0] rd_hdl;

  // held notice, so the final one can carry last
  logic                       pend_valid_r;
  logic [ost_pkg::SLOT_W-1:0] pend_slot_r;
  logic [ost_pkg::HDL_W-1:0]  pend_hdl_r;
  logic [ost_pkg::NCNT_W-1:0] ncnt_r;

  // output register
  logic                       out_valid_r;
  logic                       out_kind_r;
  ost_pkg::status_t           out_status_r;
  logic [ost_pkg::SLOT_W-1:0] out_slot_r;
  logic [ost_pkg::HDL_W-1:0]  out_hdl_r;
  logic                       out_last_r;

  logic [ost_pkg::SLOT_W-1:0] idx_slot;
  logic                       out_free;

  assign rd_cnt   = rd_data_r[ost_pkg::DUR_W-1:0];
  assign rd_hdl   = rd_data_r[ost_pkg::MEM_W-1:ost_pkg::DUR_W];
  assign idx_slot = ost_pkg::SLOT_W'(idx_r);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dur_r <= in_tdata[ost_pkg::DUR_W-1:0];
      hdl_r <= in_tdata[ost_pkg::MEM_W-1:ost_pkg::DUR_W];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    active_nxt = active_r;
    if (cmd.add_commit) begin
      active_nxt[idx_r] = 1'b1;
    end
    if (cmd.expire_clr) begin
      active_nxt[idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      active_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      active_r <= active_nxt;
    end
  end

  assign wr_en   = cmd.add_commit || cmd.dec_write;
  assign wr_data = cmd.add_commit ? {hdl_r, dur_r}
                                  : {rd_hdl, rd_cnt - ost_pkg::DUR_W'(1)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      ncnt_r       <= '0;
    end else begin
      if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.ncnt_clr) begin
        ncnt_r <= '0;
      end else if (cmd.pend_load) begin
        ncnt_r <= ncnt_r + ost_pkg::NCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_slot_r <= idx_slot;
      pend_hdl_r  <= rd_hdl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        ost_pkg::SRC_NOTICE: begin
          out_kind_r   <= ost_pkg::KIND_NOTICE;
          out_status_r <= ost_pkg::ST_OK;
          out_slot_r   <= pend_slot_r;
          out_hdl_r    <= pend_hdl_r;
          out_last_r   <= cmd.out_last;
        end
        default: begin
          out_kind_r   <= ost_pkg::KIND_REPLY;
          out_status_r <= cmd.out_status;
          out_slot_r   <= (cmd.out_status == ost_pkg::ST_OK) ? idx_slot : '0;
          out_hdl_r    <= '0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_hdl_r, out_slot_r, out_status_r};

  assign stat.add_invalid = (dur_r == '0) || (hdl_r == '0);
  assign stat.slot_active = active_r[idx_r];
  assign stat.idx_last    = (idx_r == IDX_W'(SLOT_COUNT - 1));
  assign stat.expire      = (rd_cnt == ost_pkg::DUR_W'(1));
  assign stat.pend_valid  = pend_valid_r;
  assign stat.ncnt_full   = (ncnt_r == ost_pkg::NCNT_W'(ost_pkg::MAX_NOTICES));
  assign stat.out_free    = out_free;

endmodule

`default_nettype wire

// ===== dv/one_shot_timer_slots_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_timer_slots_test: self-checking bench for the one-shot timer bank
// Walks a short table of add and tick requests (invalid, full bank, empty
// tick, eight expiries on one tick), then about four hundred random requests
// under changing back-pressure. A behavioral copy of the timer bank predicts
// every reply and expiry notice; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_slots_test;
  import ost_pkg::*;

  localparam int SLOTS       = 8;
  localparam int RAND_ITEMS  = 408;
  localparam int BIG_TAIL    = 6;     // last random adds use long durations
  localparam int HOLD_CYCLES = 400;   // long receiver stall in the last phase
  localparam int DRAIN_WAIT  = 40;    // longer than a full tick walk

  // one reply or expiry notice, as it leaves the block
  typedef struct packed {
    logic          kind;
    status_t       status;
    logic [2:0]    slot;
    logic [7:0]    fired;
    logic          last;
  } bank_res_t;

  // how a table row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // whatever the timer bank copy predicts
    CHK_REPLY,   // the single reply typed into the row
    CHK_NONE     // nothing at all may come back
  } chk_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] dur;
    logic [7:0]  hdl;
    chk_t        chk;
    bank_res_t   res;
  } plan_row_t;

  localparam bank_res_t NO_RES    = '0;
  localparam bank_res_t R_INVALID = '{KIND_REPLY, ST_INVALID, 3'd0, 8'd0, 1'b1};
  localparam bank_res_t R_FULL    = '{KIND_REPLY, ST_FULL, 3'd0, 8'd0, 1'b1};
  localparam bank_res_t R_OK_S0   = '{KIND_REPLY, ST_OK, 3'd0, 8'd0, 1'b1};
  localparam bank_res_t R_OK_S1   = '{KIND_REPLY, ST_OK, 3'd1, 8'd0, 1'b1};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [15:0] duration, [23:16] handle
  logic                  in_tuser;    // [0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;   // [1:0] status, [4:2] slot, [12:5] handle
  logic                  out_tuser;   // [0] kind
  logic                  out_tlast;

  // timer bank copy: countdown and handle per slot, zero count = free
  logic [15:0] bank_count  [SLOTS];
  logic [7:0]  bank_handle [SLOTS];

  bank_res_t   step_res[$];     // results of the request just accepted
  bank_res_t   bank_out_q[$];   // results owed by the block, oldest first
  plan_row_t   dir_plan[$];

  int          mismatches = 0;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        hold_arm;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  one_shot_timer_slots #(
    .SLOT_COUNT (SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Apply one request to the bank copy; leaves its results in step_res.
  task automatic bank_apply(input logic cmd, input logic [15:0] dur,
                            input logic [7:0] hdl);
    int        free_idx;
    bank_res_t r;
    step_res.delete();
    if (cmd == CMD_ADD) begin
      r        = '0;
      r.kind   = KIND_REPLY;
      r.status = ST_OK;
      r.last   = 1'b1;
      // null handle or zero duration is refused before looking for room
      if (dur == 16'd0 || hdl == 8'd0) begin
        r.status = ST_INVALID;
      end else begin
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (free_idx < 0 && bank_count[i] == 16'd0) free_idx = i;
        end
        if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          bank_count[free_idx]  = dur;
          bank_handle[free_idx] = hdl;
          r.slot                = free_idx[2:0];
        end
      end
      step_res.push_back(r);
    end else begin
      // tick: every active slot counts down, expiries reported in slot order
      for (int i = 0; i < SLOTS; i++) begin
        if (bank_count[i] != 16'd0) begin
          bank_count[i] = bank_count[i] - 16'd1;
          if (bank_count[i] == 16'd0) begin
            r              = '0;
            r.kind         = KIND_NOTICE;
            r.status       = ST_OK;
            r.slot         = i[2:0];
            r.fired        = bank_handle[i];
            bank_handle[i] = 8'd0;
            if (step_res.size() < MAX_NOTICES) step_res.push_back(r);
          end
        end
      end
      if (step_res.size() > 0) begin
        r      = step_res[step_res.size()-1];
        r.last = 1'b1;
        step_res[step_res.size()-1] = r;
      end
    end
  endtask

  // Offer one request, wait for it to be taken, then book what it owes.
  // Called and returns right after a rising edge.
  task automatic send_request(input logic cmd, input logic [15:0] dur,
                              input logic [7:0] hdl, input chk_t chk,
                              input bank_res_t typed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hdl, dur};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // taken at this edge; the bank copy always moves, typed rows override
    bank_apply(cmd, dur, hdl);
    case (chk)
      CHK_MODEL: begin
        foreach (step_res[k]) bank_out_q.push_back(step_res[k]);
      end
      CHK_REPLY: begin
        bank_out_q.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  function automatic plan_row_t row(input logic cmd, input logic [15:0] dur,
                                    input logic [7:0] hdl, input chk_t chk,
                                    input bank_res_t res);
    plan_row_t p;
    p.cmd = cmd;
    p.dur = dur;
    p.hdl = hdl;
    p.chk = chk;
    p.res = res;
    return p;
  endfunction

  // Receiver: random tready, plus one long hold armed from the stimulus side.
  // The hold is counted here so the stall length does not depend on stimulus.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest one owed.
  always @(posedge clk) begin
    bank_res_t want;
    bank_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.status = status_t'(out_tdata[1:0]);
      got.slot   = out_tdata[4:2];
      got.fired  = out_tdata[12:5];
      got.last   = out_tlast;
      if (bank_out_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result kind=%0d status=%0d slot=%0d handle=%0d last=%0d",
                   $realtime, got.kind, got.status, got.slot, got.fired, got.last);
        mismatches++;
      end else begin
        want = bank_out_q.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.slot !== want.slot || got.fired !== want.fired ||
            got.last !== want.last) begin
          if (mismatches < 10)
            $display("%0t: exp kind=%0d status=%0d slot=%0d handle=%0d last=%0d,",
                     $realtime, want.kind, want.status, want.slot, want.fired, want.last,
                     " got %0d %0d %0d %0d %0d",
                     got.kind, got.status, got.slot, got.fired, got.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("one_shot_timer_slots: mismatch");
    $finish;
  end

  initial begin
    int          pick;
    logic        cmd;
    logic [15:0] dur;
    logic [7:0]  hdl;
    plan_row_t   p;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = CMD_ADD;
    in_tdata    = '0;
    hold_arm    = 1'b0;
    tx_idle_pct = 27;
    rx_idle_pct = 72;
    for (int i = 0; i < SLOTS; i++) begin
      bank_count[i]  = 16'd0;
      bank_handle[i] = 8'd0;
    end

    // directed table
    dir_plan.push_back(row(CMD_TICK, 16'd0,     8'd0,   CHK_NONE,  NO_RES));    // empty bank
    dir_plan.push_back(row(CMD_ADD,  16'd0,     8'd5,   CHK_REPLY, R_INVALID)); // zero duration
    dir_plan.push_back(row(CMD_ADD,  16'd5,     8'd0,   CHK_REPLY, R_INVALID)); // null handle
    dir_plan.push_back(row(CMD_ADD,  16'hFFFF,  8'd0,   CHK_REPLY, R_INVALID));
    dir_plan.push_back(row(CMD_ADD,  16'd1,     8'hFF,  CHK_REPLY, R_OK_S0));
    dir_plan.push_back(row(CMD_TICK, 16'd0,     8'd0,   CHK_MODEL, NO_RES));
    // fill all slots with the same count, one handle bit each
    for (int i = 0; i < SLOTS; i++)
      dir_plan.push_back(row(CMD_ADD, 16'd2, 8'(1 << i), CHK_MODEL, NO_RES));
    dir_plan.push_back(row(CMD_ADD,  16'hFFFF,  8'hFF,  CHK_REPLY, R_FULL));
    // invalid wins over full
    dir_plan.push_back(row(CMD_ADD,  16'd0,     8'd0,   CHK_REPLY, R_INVALID));
    dir_plan.push_back(row(CMD_TICK, 16'd0,     8'd0,   CHK_MODEL, NO_RES));
    // all eight slots run out together
    dir_plan.push_back(row(CMD_TICK, 16'd0,     8'd0,   CHK_MODEL, NO_RES));
    dir_plan.push_back(row(CMD_ADD,  16'd3,     8'h5A,  CHK_REPLY, R_OK_S0));
    dir_plan.push_back(row(CMD_ADD,  16'd1,     8'hA5,  CHK_REPLY, R_OK_S1));
    dir_plan.push_back(row(CMD_TICK, 16'd0,     8'd0,   CHK_MODEL, NO_RES));
    // slot 1 freed, slot 0 still busy
    dir_plan.push_back(row(CMD_ADD,  16'd7,     8'h33,  CHK_REPLY, R_OK_S1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_plan[i]) begin
      p = dir_plan[i];
      send_request(p.cmd, p.dur, p.hdl, p.chk, p.res);
    end

    // random part, three back-pressure phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        tx_idle_pct = 72;
        rx_idle_pct = 27;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_arm    = 1'b1;  // sender keeps offering while results back up
      end
      pick = $urandom_range(99);
      if (n >= RAND_ITEMS - BIG_TAIL) begin
        // long timers only at the end, where they cannot clog the bank
        cmd = CMD_ADD;
        dur = 16'($urandom_range(16'hFFFF, 16'h1000));
        hdl = 8'($urandom_range(255, 1));
      end else if (pick < 45) begin
        cmd = CMD_TICK;
        dur = 16'($urandom);
        hdl = 8'($urandom);
      end else if (pick < 88) begin
        cmd = CMD_ADD;
        dur = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 1))
                                       : 16'($urandom_range(12, 1));
        hdl = 8'($urandom_range(255, 1));
      end else begin
        // refused adds with wide random content
        cmd = CMD_ADD;
        if ($urandom_range(1) == 0) begin
          dur = 16'd0;
          hdl = 8'($urandom);
        end else begin
          dur = 16'($urandom);
          hdl = 8'd0;
        end
      end
      send_request(cmd, dur, hdl, CHK_MODEL, NO_RES);
    end
    in_tvalid <= 1'b0;

    while (bank_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("one_shot_timer_slots: match");
    end else begin
      $display("one_shot_timer_slots: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ost_pkg.sv
hw/rtl/ost_ctrl.sv
hw/rtl/ost_dp.sv
hw/rtl/one_shot_timer_slots.sv
dv/one_shot_timer_slots_test.sv
